/* rtl/ttcw_pkg.sv */
// ttcw_pkg: screen geometry, field widths, codes and shared types for the
// character terminal writer. No dependencies.
`timescale 1ns / 1ps

package ttcw_pkg;

    localparam int COLUMNS    = 40;
    localparam int LINES      = 24;
    localparam int CELL_COUNT = COLUMNS * LINES;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 10;
    localparam int COL_W  = 6;
    localparam int ROW_W  = 5;
    localparam int CODE_W = 6;
    localparam int ASCII_W = 7;

    localparam logic [ASCII_W-1:0] CHAR_CR        = 7'h0D;
    localparam logic [ASCII_W-1:0] CHAR_PRINT_MIN = 7'h20;
    localparam logic [CODE_W-1:0]  BLANK_RESET    = 6'd32;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CODE_W-1:0] glyph;
        logic [ADDR_W-1:0] offs;
        logic              moved;
        logic              store;
        logic              scroll;
    } t_cur_upd;

endpackage

/* rtl/ttcw_ram.sv */
// ttcw_ram: screen cell memory, one write port and one registered read port.
// Depends on ttcw_pkg.
`timescale 1ns / 1ps

module ttcw_ram
    import ttcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [CODE_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [CODE_W-1:0] o_rdata
);

    logic [CODE_W-1:0] r_mem [CELL_COUNT];
    logic [CODE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ttcw_cursor.sv */
// ttcw_cursor: decodes one display byte against the cursor: glyph, cell
// offset, next cursor and scroll request. Depends on ttcw_pkg.
`timescale 1ns / 1ps

module ttcw_cursor
    import ttcw_pkg::*;
(
    input  logic [COL_W-1:0]   i_col,
    input  logic [ROW_W-1:0]   i_row,
    input  logic [CHAR_W-1:0]  i_char,
    output t_cur_upd           o_upd
);

    logic [ASCII_W-1:0] ch;
    logic [ROW_W:0]     row_inc;
    logic               adv_row;

    assign ch      = i_char[ASCII_W-1:0];
    assign row_inc = {1'b0, i_row} + (ROW_W+1)'(1);

    always_comb begin
        o_upd.glyph = {~ch[6], ch[4:0]};
        o_upd.offs  = ADDR_W'(i_row) * ADDR_W'(COLUMNS) + ADDR_W'(i_col);
        o_upd.col   = i_col;
        o_upd.row   = i_row;
        o_upd.moved = 1'b1;
        o_upd.store = 1'b0;
        adv_row     = 1'b0;
        if (ch == CHAR_CR) begin
            o_upd.col = '0;
            adv_row   = 1'b1;
        end else if (ch < CHAR_PRINT_MIN) begin
            o_upd.moved = 1'b0;
        end else begin
            o_upd.store = 1'b1;
            if (i_col < COL_W'(COLUMNS - 1)) begin
                o_upd.col = i_col + COL_W'(1);
            end else begin
                o_upd.col = '0;
                adv_row   = 1'b1;
            end
        end
        o_upd.scroll = adv_row && (row_inc >= (ROW_W+1)'(LINES));
        if (adv_row) begin
            o_upd.row = o_upd.scroll ? ROW_W'(LINES - 1) : row_inc[ROW_W-1:0];
        end
    end

endmodule

/* rtl/text_terminal_char_writer.sv */
// text_terminal_char_writer: top level, sequencer over the shared cell
// address counter and memory port. Depends on ttcw_pkg, ttcw_ram, ttcw_cursor.
`timescale 1ns / 1ps

// A 40x24 terminal screen of 6-bit glyph codes with a cursor. After reset the
// block sweeps the screen to the blank code before taking its first item.
// A display write that does not scroll, an ignored write and the unused
// operation code finish in the accepting cycle. A read passes through the
// S_READ and S_DONE states. Clear and a write that scrolls walk the cell
// memory one cell per cycle with one address counter (a scroll copies 920
// cells up one row, then blanks the last row). The next item is taken once
// the block is idle and the result register is free.
module text_terminal_char_writer
    import ttcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CODE_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [CHAR_W-1:0] i_char_in,
    input  logic              i_clear_held,
    input  logic [IDX_W-1:0]  i_cell_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [COL_W-1:0]  o_cursor_column,
    output logic [ROW_W-1:0]  o_cursor_line,
    output logic [CODE_W-1:0] o_cell_code,
    output logic              o_stored,
    output logic              o_scrolled
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_DRAIN,
        S_FILL,
        S_DONE
    } t_state;

    localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELL_COUNT - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW0  = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);

    t_state            r_state;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_cp_addr;
    logic              r_cp_valid;
    logic [CODE_W-1:0] r_fill_code;
    logic [CODE_W-1:0] r_blank_code;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic              r_rd_oob;
    logic [CODE_W-1:0] r_res_code;
    logic              r_res_stored;
    logic              r_res_scrolled;
    logic              r_out_valid;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [CODE_W-1:0] r_out_code;
    logic              r_out_stored;
    logic              r_out_scrolled;

    t_cur_upd          upd;
    t_op               op;
    logic              accept;
    logic              out_free;
    logic              out_load;
    logic              wr_eff;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CODE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CODE_W-1:0] ram_rdata;

    ttcw_cursor u_cursor (
        .i_col  (r_col),
        .i_row  (r_row),
        .i_char (i_char_in),
        .o_upd  (upd)
    );

    ttcw_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign op         = t_op'(i_operation);
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign wr_eff     = (op == OP_WRITE) && !i_clear_held;
    assign out_load   = (accept && !(op == OP_CLEAR || op == OP_READ || (wr_eff && upd.scroll)))
                        || (r_state == S_DONE && out_free);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = r_fill_code;
        ram_raddr = ADDR_W'(i_cell_index);
        if (accept && wr_eff && upd.store) begin
            ram_we    = 1'b1;
            ram_waddr = upd.offs;
            ram_wdata = upd.glyph;
        end else if (r_cp_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_cp_addr;
            ram_wdata = ram_rdata;
        end else if (r_state == S_FILL || r_state == S_INIT) begin
            ram_we = 1'b1;
        end
        if (r_state == S_SCROLL) begin
            ram_raddr = r_addr + ADDR_W'(COLUMNS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_INIT;
            r_addr         <= '0;
            r_cp_valid     <= 1'b0;
            r_fill_code    <= BLANK_RESET;
            r_blank_code   <= BLANK_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_blank_code <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT, S_FILL: begin
                    if (r_addr == LAST_CELL) begin
                        r_state <= (r_state == S_INIT) ? S_IDLE : S_DONE;
                    end else begin
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_res_code     <= '0;
                        r_res_stored   <= wr_eff && upd.scroll && upd.store;
                        r_res_scrolled <= wr_eff && upd.scroll;
                        r_rd_oob       <= (i_cell_index >= IDX_W'(CELL_COUNT));
                        unique case (op)
                            OP_WRITE: begin
                                if (wr_eff && upd.moved) begin
                                    r_col <= upd.col;
                                    r_row <= upd.row;
                                end
                                if (wr_eff && upd.scroll) begin
                                    r_addr  <= '0;
                                    r_state <= S_SCROLL;
                                end else begin
                                    r_out_col      <= (wr_eff && upd.moved) ? upd.col : r_col;
                                    r_out_row      <= (wr_eff && upd.moved) ? upd.row : r_row;
                                    r_out_code     <= '0;
                                    r_out_stored   <= wr_eff && upd.store;
                                    r_out_scrolled <= 1'b0;
                                end
                            end
                            OP_CLEAR: begin
                                r_col       <= '0;
                                r_row       <= '0;
                                r_addr      <= '0;
                                r_fill_code <= r_blank_code;
                                r_state     <= S_FILL;
                            end
                            OP_READ: begin
                                r_state <= S_READ;
                            end
                            default: begin
                                r_out_col      <= r_col;
                                r_out_row      <= r_row;
                                r_out_code     <= '0;
                                r_out_stored   <= 1'b0;
                                r_out_scrolled <= 1'b0;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_res_code <= r_rd_oob ? '0 : ram_rdata;
                    r_state    <= S_DONE;
                end
                S_SCROLL: begin
                    r_cp_valid <= 1'b1;
                    r_cp_addr  <= r_addr;
                    if (r_addr == LAST_COPY) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_cp_valid  <= 1'b0;
                    r_addr      <= LAST_ROW0;
                    r_fill_code <= r_blank_code;
                    r_state     <= S_FILL;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_col      <= r_col;
                        r_out_row      <= r_row;
                        r_out_code     <= r_res_code;
                        r_out_stored   <= r_res_stored;
                        r_out_scrolled <= r_res_scrolled;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cursor_column = r_out_col;
    assign o_cursor_line   = r_out_row;
    assign o_cell_code     = r_out_code;
    assign o_stored        = r_out_stored;
    assign o_scrolled      = r_out_scrolled;

    a_scroll_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL) |-> (r_row == ROW_W'(LINES - 1)))
        else $error("cursor not on last row during scroll");

    a_copy_in_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_valid |-> (r_state == S_SCROLL || r_state == S_DRAIN))
        else $error("cell copy pending outside scroll");

    a_read_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && op == OP_READ) |=> (r_state == S_READ))
        else $error("read transfer did not start a read");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL || r_state == S_INIT) |-> (r_addr <= LAST_CELL))
        else $error("fill address out of range");

endmodule

/* verif/tb.sv */
// tb: self-checking testbench for text_terminal_char_writer.
// Keeps its own screen image, cursor and blank code to predict every status transfer.
// Depends on ttcw_pkg and the text_terminal_char_writer RTL.
`timescale 1ns / 1ps

module tb;
    import ttcw_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDX_MAX           = (1 << IDX_W) - 1;
    localparam int WATCHDOG_LIMIT    = 5000;
    localparam int SINK_HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES       = 1000;
    localparam int MAX_REPORTS       = 10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic              held;
        logic [IDX_W-1:0]  idx;
    } t_term_cmd;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CODE_W-1:0] code;
        logic              stored;
        logic              scrolled;
    } t_term_status;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CODE_W-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [OP_W-1:0]   i_operation = '0;
    logic [CHAR_W-1:0] i_char_in = '0;
    logic              i_clear_held = 1'b0;
    logic [IDX_W-1:0]  i_cell_index = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [COL_W-1:0]  o_cursor_column;
    logic [ROW_W-1:0]  o_cursor_line;
    logic [CODE_W-1:0] o_cell_code;
    logic              o_stored;
    logic              o_scrolled;

    // screen image and cursor
    logic [CODE_W-1:0] screen_img [CELL_COUNT];
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [CODE_W-1:0] blank_glyph;

    t_term_status status_due_q [$];
    int unsigned  fail_count = 0;
    bit           idle_enable = 1'b1;
    int unsigned  hold_req_count = 0;
    int unsigned  hold_done_count = 0;

    text_terminal_char_writer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_char_in       (i_char_in),
        .i_clear_held    (i_clear_held),
        .i_cell_index    (i_cell_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cursor_column (o_cursor_column),
        .o_cursor_line   (o_cursor_line),
        .o_cell_code     (o_cell_code),
        .o_stored        (o_stored),
        .o_scrolled      (o_scrolled)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++) begin
            screen_img[i] = blank_glyph;
        end
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
            screen_img[i] = screen_img[i + COLUMNS];
        end
        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
            screen_img[i] = blank_glyph;
        end
    endfunction

    function automatic t_term_status apply_to_screen(t_term_cmd cmd);
        t_term_status       st;
        logic [ASCII_W-1:0] code7;
        int                 col;
        int                 row;
        bit                 moved;
        st = '0;
        code7 = cmd.ch[ASCII_W-1:0];
        case (cmd.op)
            OP_WRITE: begin
                if (!cmd.held) begin
                    col = cur_col;
                    row = cur_row;
                    moved = 1'b1;
                    if (code7 == CHAR_CR) begin
                        col = 0;
                        row++;
                    end else if (code7 < CHAR_PRINT_MIN) begin
                        moved = 1'b0;
                    end else begin
                        screen_img[row * COLUMNS + col] = {~code7[6], code7[4:0]};
                        st.stored = 1'b1;
                        if (col < COLUMNS - 1) begin
                            col++;
                        end else begin
                            col = 0;
                            row++;
                        end
                    end
                    if (moved) begin
                        if (row >= LINES) begin
                            scroll_screen();
                            st.scrolled = 1'b1;
                            row = LINES - 1;
                        end
                        cur_col = COL_W'(col);
                        cur_row = ROW_W'(row);
                    end
                end
            end
            OP_CLEAR: begin
                blank_screen();
                cur_col = '0;
                cur_row = '0;
            end
            OP_READ: begin
                if (cmd.idx < CELL_COUNT) begin
                    st.code = screen_img[cmd.idx];
                end
            end
            default: begin
            end
        endcase
        st.col = cur_col;
        st.row = cur_row;
        return st;
    endfunction

    // one input transfer; valid stays high on return
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic held, input logic [IDX_W-1:0] idx);
        t_term_cmd cmd;
        cmd = '{op: op, ch: ch, held: held, idx: idx};
        if (idle_enable && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_char_in    <= ch;
        i_clear_held <= held;
        i_cell_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        status_due_q.push_back(apply_to_screen(cmd));
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_cmd(OP_WRITE, ch, 1'b0, IDX_W'($urandom_range(IDX_MAX)));
    endtask

    task automatic read_cell(input int idx);
        send_cmd(OP_READ, CHAR_W'($urandom), 1'($urandom), IDX_W'(idx));
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (status_due_q.size() != 0);
    endtask

    task automatic write_blank_code(input logic [CODE_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        blank_glyph = value;
    endtask

    task automatic test_directed_basics();
        read_cell(0);
        read_cell(CELL_COUNT - 1);
        read_cell(CELL_COUNT);
        read_cell(IDX_MAX);
        put_char(8'h41);
        put_char(8'hC1);
        put_char(8'h20);
        put_char(8'h7F);
        put_char(8'h60);
        put_char(8'h00);
        put_char(8'h1F);
        put_char({1'b1, CHAR_CR});
        put_char({1'b0, CHAR_CR});
        send_cmd(OP_WRITE, 8'h5A, 1'b1, '0);
        send_cmd(OP_UNUSED, 8'hFF, 1'b1, IDX_W'(IDX_MAX));
        read_cell(0);
        read_cell(4);
        read_cell(3);
        send_cmd(OP_CLEAR, 8'h41, 1'b1, '0);
        read_cell(0);
        put_char(8'h42);
        wait_for_results();
    endtask

    task automatic test_blank_register();
        write_blank_code(6'd63);
        send_cmd(OP_CLEAR, 8'h00, 1'b0, '0);
        read_cell(CELL_COUNT - 1);
        wait_for_results();
        write_blank_code(6'd0);
        read_cell(0);
        wait_for_results();
    endtask

    // text lines ended by carriage return, with reads, clears and noise mixed in
    task automatic test_random_text(input int n_items);
        int                sent;
        int                line_len;
        int                idx;
        int                roll;
        logic [CHAR_W-1:0] ch;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
                roll = $urandom_range(99);
                if (roll < 70) begin
                    line_len = $urandom_range(4);
                end else if (roll < 95) begin
                    line_len = $urandom_range(5, COLUMNS - 1);
                end else begin
                    line_len = $urandom_range(COLUMNS, 2 * COLUMNS);
                end
                for (int k = 0; k < line_len && sent < n_items; k++) begin
                    ch = CHAR_W'($urandom_range(32, 127));
                    ch[7] = 1'($urandom);
                    put_char(ch);
                    sent++;
                end
                if (sent < n_items) begin
                    put_char({1'($urandom), CHAR_CR});
                    sent++;
                end
            end else if (roll < 80) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        idx = cur_row * COLUMNS + cur_col - 1;
                        if (idx < 0) begin
                            idx = 0;
                        end
                    end
                    4, 5, 6: idx = $urandom_range(CELL_COUNT - 1);
                    7, 8: idx = (LINES - 1 - $urandom_range(1)) * COLUMNS
                                + $urandom_range(COLUMNS - 1);
                    default: idx = $urandom_range(CELL_COUNT, IDX_MAX);
                endcase
                read_cell(idx);
                sent++;
            end else if (roll < 95) begin
                ch = CHAR_W'($urandom);
                case ($urandom_range(3))
                    0: put_char({ch[7], 2'b00, ch[4:0]});
                    1: send_cmd(OP_WRITE, ch, 1'b1, IDX_W'($urandom));
                    2: send_cmd(OP_UNUSED, ch, 1'($urandom), IDX_W'($urandom));
                    default: begin
                        put_char(ch);
                        sent++;
                    end
                endcase
            end else if (roll < 96) begin
                send_cmd(OP_CLEAR, CHAR_W'($urandom), 1'($urandom), IDX_W'($urandom));
                sent++;
            end else if (roll < 98) begin
                wait_for_results();
            end
        end
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        hold_req_count++;
        test_random_text(30);
    endtask

    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
            end else if (hold_done_count != hold_req_count) begin
                hold_done_count++;
                hold_left = SINK_HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !idle_enable || ($urandom_range(99) >= 7);
            end
        end
    end

    initial begin : status_check
        t_term_status got;
        t_term_status want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got = '{col: o_cursor_column, row: o_cursor_line, code: o_cell_code,
                        stored: o_stored, scrolled: o_scrolled};
                if (status_due_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected status transfer col=%0d row=%0d", $realtime,
                                 got.col, got.row);
                    end
                end else begin
                    want = status_due_q.pop_front();
                    if (got != want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch exp col=%0d row=%0d code=%0d st=%0b sc=%0b",
                                     $realtime, want.col, want.row, want.code, want.stored,
                                     want.scrolled);
                            $display("%0t:          got col=%0d row=%0d code=%0d st=%0b sc=%0b",
                                     $realtime, got.col, got.row, got.code, got.stored,
                                     got.scrolled);
                        end
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        blank_glyph = BLANK_RESET;
        blank_screen();
        cur_col = '0;
        cur_row = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_basics();
        test_blank_register();
        test_random_text(200);
        test_output_backpressure();
        write_blank_code(6'd63);
        idle_enable = 1'b0;
        test_random_text(150);
        idle_enable = 1'b1;
        write_blank_code(CODE_W'($urandom));
        test_random_text(170);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && status_due_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* text_terminal_char_writer.f */
rtl/ttcw_pkg.sv
rtl/ttcw_ram.sv
rtl/ttcw_cursor.sv
rtl/text_terminal_char_writer.sv
verif/tb.sv
